[src/mwg_pkg.sv]
// ----------------------------------------------------------------------------
// mwg_pkg: shared definitions for the multi-waveform generator
// Widths, register and waveform codes, and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package mwg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int ROM_SIZE        = 1 << SINE_TABLE_BITS;

    localparam int SAMPLE_BITS     = 16;
    localparam int SELECT_BITS     = 3;
    localparam int STEP_BITS       = 32;
    localparam int AMP_BITS        = 19;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM_SELECT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE       = 2'd2;

    // waveform codes
    localparam logic [SELECT_BITS-1:0] WAVE_SINE     = 3'd0;
    localparam logic [SELECT_BITS-1:0] WAVE_SAWTOOTH = 3'd1;
    localparam logic [SELECT_BITS-1:0] WAVE_SQUARE   = 3'd2;
    localparam logic [SELECT_BITS-1:0] WAVE_TRIANGLE = 3'd3;

    // pi/2 in Q30 and the Taylor series divisors (2n)(2n+1)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

    typedef logic [SAMPLE_BITS-1:0] sine_table_t [ROM_SIZE];

    // Quarter-wave table, evaluated at elaboration: round(32768 * sin(pi/2 * k / N))
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k < ROM_SIZE; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
                if ((n & 1) != 0) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum + 64'd16384) >> 15;
            if (v > 64'd32768) begin
                v = 64'd32768;
            end
            tbl[k] = v[SAMPLE_BITS-1:0];
        end
        return tbl;
    endfunction

endpackage

[src/multi_waveform_generator.sv]
// ----------------------------------------------------------------------------
// multi_waveform_generator: phase-accumulator function generator
// Sine, sawtooth, square and triangle samples scaled by a programmable amplitude.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_valid/s_ready/s_restart): each accepted item asks for one
//   sample; s_restart = 1 zeroes the phase before that sample is formed.
//   Result channel (m_valid/m_ready): one item per input item, carrying
//   m_sample_value (signed 16 bit) and m_clipped (saturation flag).
//   Configuration (cfg_wr_en/cfg_index/cfg_wr_data): waveform select, phase
//   step and Q0.19 amplitude; write only while no item is in flight.
// Pipeline and throughput
//   An item passes the stage one registers, then the result register; one item
//   per cycle is sustained while m_ready is high. Stage one: sine ROM read and
//   phase update; stage two: waveform value, amplitude multiply and saturation.
// Reset
//   aresetn (synchronous, active low) clears the phase, the config registers and
//   both valid flags; the sine table is a constant ROM and needs no fill.
// Stalls
//   With m_ready low the result is held; one more item may enter stage one,
//   after which s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module multi_waveform_generator (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_restart,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mwg_pkg::SAMPLE_BITS-1:0] m_sample_value,
    output logic                                   m_clipped,
    input  logic                                   cfg_wr_en,
    input  logic [mwg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mwg_pkg::CFG_DATA_BITS-1:0]      cfg_wr_data
);
    import mwg_pkg::*;

    localparam sine_table_t SINE_ROM = build_sine_table();

    // configuration
    logic [SELECT_BITS-1:0]  wave_sel_reg;
    logic [STEP_BITS-1:0]    phase_step_reg;
    logic [AMP_BITS-1:0]     amplitude_reg;

    // phase and stage one
    logic [PHASE_BITS-1:0]      phase_accum_reg;
    logic [PHASE_BITS-1:0]      phase_cur;
    logic [PHASE_BITS-1:0]      step_ext;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-1:0] rom_addr;
    logic                       s1_valid_reg;
    logic [SAMPLE_BITS-1:0]     rom_data_reg;
    logic                       peak_reg;
    logic [1:0]                 quad_reg;
    logic [15:0]                u_reg;
    logic                       sq_pos_reg;

    // stage two
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                         clipped_reg;

    logic                  advance;
    logic                  accept;
    logic [16:0]           mag_sine;
    logic [16:0]           abs_d;
    logic signed [18:0]    w_s;
    logic                  w_neg;
    logic [18:0]           w_abs;
    logic [35:0]           product;
    logic [16:0]           scaled;
    logic [16:0]           sat_mag;
    logic                  clip_next;
    logic [SAMPLE_BITS-1:0] sample_next;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance || !s1_valid_reg;
    assign accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_sel_reg   <= WAVE_SINE;
            phase_step_reg <= '0;
            amplitude_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WAVEFORM_SELECT: wave_sel_reg   <= cfg_wr_data[SELECT_BITS-1:0];
                REG_PHASE_STEP:      phase_step_reg <= cfg_wr_data[STEP_BITS-1:0];
                REG_AMPLITUDE:       amplitude_reg  <= cfg_wr_data[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage one: phase select, ROM address, flags
    assign step_ext  = PHASE_BITS'(phase_step_reg);
    assign phase_cur = s_restart ? '0 : phase_accum_reg;
    assign idx       = phase_cur[PHASE_BITS-3 -: SINE_TABLE_BITS];
    // falling quadrants mirror the index; a mirrored zero index is the peak
    assign rom_addr  = phase_cur[PHASE_BITS-2] ? SINE_TABLE_BITS'(0) - idx : idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_accum_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_accum_reg <= phase_cur + step_ext;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rom_data_reg <= SINE_ROM[rom_addr];
            peak_reg     <= phase_cur[PHASE_BITS-2] && (idx == '0);
            quad_reg     <= phase_cur[PHASE_BITS-1 -: 2];
            u_reg        <= phase_cur[PHASE_BITS-1 -: 16];
            sq_pos_reg   <= !phase_cur[PHASE_BITS-1] && (phase_cur != '0);
        end
    end

    // stage two: waveform value, scale, saturate
    assign mag_sine = peak_reg ? 17'd32768 : {1'b0, rom_data_reg};
    assign abs_d    = u_reg[15] ? {2'b00, u_reg[14:0]} : 17'd32768 - {1'b0, u_reg};

    always_comb begin
        unique case (wave_sel_reg)
            WAVE_SINE: begin
                w_s = quad_reg[1] ? -$signed({2'b00, mag_sine}) : $signed({2'b00, mag_sine});
            end
            WAVE_SAWTOOTH: w_s = $signed({3'b000, u_reg}) - 19'sd32768;
            WAVE_SQUARE:   w_s = sq_pos_reg ? 19'sd32768 : -19'sd32768;
            WAVE_TRIANGLE: w_s = $signed({1'b0, abs_d, 1'b0}) - 19'sd32768;
            default:       w_s = '0;
        endcase
    end

    assign w_neg   = w_s[18];
    assign w_abs   = w_neg ? 19'(-w_s) : 19'(w_s);
    assign product = 36'(w_abs[16:0]) * 36'(amplitude_reg);
    assign scaled  = product[35:19];

    always_comb begin
        if (w_neg) begin
            clip_next = scaled > 17'd32768;
            sat_mag   = clip_next ? 17'd32768 : scaled;
            sample_next = SAMPLE_BITS'(17'd0 - sat_mag);
        end else begin
            clip_next = scaled > 17'd32767;
            sat_mag   = clip_next ? 17'd32767 : scaled;
            sample_next = sat_mag[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            sample_reg  <= $signed(sample_next);
            clipped_reg <= clip_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sample_value = sample_reg;
    assign m_clipped      = clipped_reg;

    // checks
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are full and stalled");

    a_restart_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_restart) |=> (phase_accum_reg == $past(step_ext)))
        else $error("restart did not zero the phase");

    a_clip_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clipped) |->
            (m_sample_value == 16'sh7fff || m_sample_value == -16'sh8000))
        else $error("clip flag without saturated sample");

    a_unused_select_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && s1_valid_reg && wave_sel_reg[2]) |=> (m_sample_value == '0 && !m_clipped))
        else $error("unused waveform select gave a non-zero sample");

endmodule
